>>> hdl/assert_macros.svh
// Assertion helpers. Every check is clocked on clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tdc_pkg.sv
package tdc_pkg;

	localparam logic [1:0] REQ_SAMPLE  = 2'd0;
	localparam logic [1:0] REQ_BUTTONS = 2'd1;
	localparam logic [1:0] REQ_SCAN    = 2'd2;

	localparam logic [4:0] CODE_F     = 5'd15;
	localparam logic [4:0] CODE_MINUS = 5'd16;
	localparam logic [4:0] CODE_BLANK = 5'd18;
	localparam logic [4:0] CODE_UPPER = 5'd21;
	localparam logic [4:0] CODE_LOWER = 5'd22;
	localparam logic [4:0] CODE_ONE   = 5'd1;

	localparam logic signed [15:0] ERROR_TEMP   = -16'sd9999;
	localparam logic signed [7:0]  SET_MAX      = 8'sd99;
	localparam logic signed [7:0]  SET_MIN      = -8'sd99;
	localparam logic signed [7:0]  LOW_DEFAULT  = -8'sd3;
	localparam logic signed [7:0]  HIGH_DEFAULT = 8'sd3;
	localparam logic [6:0]         WHOLE_MAX    = 7'd99;
	localparam logic [1:0]         POINT_DIGIT  = 2'd2;

	typedef enum logic [1:0] {
		MENU_VIEW,
		MENU_EDIT_LOW,
		MENU_EDIT_HIGH
	} menu_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] raw_temp;
		logic [3:0]         buttons;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        segments;
		logic [3:0]        digit_select;
		logic              relay_on;
		logic              thermostat_on;
		logic [1:0]        menu_state;
		logic signed [7:0] shown_temp;
	} out_item_t;

	// Quotient by ten through the reciprocal 205/2048, exact for values up to 99.
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] prod;
		prod = 15'(v) * 15'd205;
		return prod[14:11];
	endfunction

	function automatic logic [3:0] ones_of(input logic [6:0] v);
		logic [6:0] back;
		back = 7'(tens_of(v)) * 7'd10;
		return 4'(v - back);
	endfunction

	// Step a setpoint by one and hold it inside -99..99.
	function automatic logic signed [7:0] step_set(input logic signed [7:0] v,
		input logic up);
		logic signed [8:0] s;
		s = up ? (9'(v) + 9'sd1) : (9'(v) - 9'sd1);
		if (s > 9'(SET_MAX)) begin
			return SET_MAX;
		end else if (s < 9'(SET_MIN)) begin
			return SET_MIN;
		end
		return 8'(s);
	endfunction

	// Active-low segments: A=bit0, E=bit1, D=bit2, DP=bit3, C=bit4, G=bit5, F=bit6, B=bit7.
	function automatic logic [7:0] glyph(input logic [4:0] code);
		logic [7:0] g;
		case (code)
			5'd0:    g = 8'h28;
			5'd1:    g = 8'h6F;
			5'd2:    g = 8'h58;
			5'd3:    g = 8'h4A;
			5'd4:    g = 8'h0F;
			5'd5:    g = 8'h8A;
			5'd6:    g = 8'h88;
			5'd7:    g = 8'h6E;
			5'd8:    g = 8'h08;
			5'd9:    g = 8'h0A;
			5'd10:   g = 8'h0C;
			5'd11:   g = 8'h89;
			5'd12:   g = 8'hB8;
			5'd13:   g = 8'h49;
			5'd14:   g = 8'h98;
			5'd15:   g = 8'h9C;
			5'd16:   g = 8'hDF;
			5'd17:   g = 8'h1E;
			5'd19:   g = 8'hCD;
			5'd20:   g = 8'h99;
			5'd21:   g = 8'hFE;
			5'd22:   g = 8'hFB;
			default: g = 8'hFF;
		endcase
		return g;
	endfunction

	function automatic logic [3:0] pin_of(input logic [1:0] pos);
		logic [3:0] p;
		unique case (pos)
			2'd0:    p = 4'd2;
			2'd1:    p = 4'd4;
			2'd2:    p = 4'd8;
			default: p = 4'd1;
		endcase
		return p;
	endfunction

endpackage

>>> hdl/thermostat_display_controller_core.sv
// Thermostat controller with a four-digit multiplexed seven-segment display. Each input
// item is a temperature sample (1/16 degree), a button poll or a display scan tick, and
// each yields exactly one result item: the driven digit's segments and common pin (dark
// for anything but a scan tick), the relay, the mode, the menu state and the last rounded
// temperature. An item is registered on acceptance and its result is formed from that
// register into the output register, so one item is taken per cycle while out_stall is low;
// the output register lets a new item enter while a result waits on out_stall.
`include "assert_macros.svh"

module thermostat_display_controller_core import tdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	in_item_t          item_s1;
	logic              valid_s1;
	logic              advance;

	logic              thermo_q, thermo_d;
	menu_t             menu_q, menu_d;
	logic signed [7:0] low_q, low_d;
	logic signed [7:0] high_q, high_d;
	logic signed [7:0] temp_q, temp_d;
	logic              relay_q, relay_d;
	logic [4:0]        digits_q [4];
	logic [4:0]        digits_d [4];
	logic              point_q, point_d;
	logic [1:0]        scan_q, scan_d;

	out_item_t         out_q, out_d;
	logic              out_valid_q;

	// Combinational work on the registered item.
	logic signed [15:0] t;
	logic               neg;
	logic [15:0]        mag;
	logic [11:0]        whole;
	logic [7:0]         tenth_x;
	logic [3:0]         tenth;
	logic [6:0]         w7;
	logic [6:0]         r;
	logic [4:0]         sign_code;
	logic               up_b, down_b, onoff_b, menu_b;
	logic signed [7:0]  sp_val;
	logic [6:0]         sp_mag;
	logic [4:0]         sp_sign;
	logic [4:0]         code;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !(!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		thermo_d = thermo_q;
		menu_d   = menu_q;
		low_d    = low_q;
		high_d   = high_q;
		temp_d   = temp_q;
		relay_d  = relay_q;
		digits_d = digits_q;
		point_d  = point_q;
		scan_d   = scan_q;

		t         = item_s1.raw_temp;
		neg       = t[15];
		mag       = neg ? 16'(-t) : 16'(t);
		whole     = mag[15:4];
		tenth_x   = {1'b0, mag[3:0], 3'b000} + {3'b000, mag[3:0], 1'b0};
		tenth     = tenth_x[7:4];
		w7        = whole[6:0];
		r         = w7 + 7'((tenth >= 4'd5) ? 1 : 0);
		sign_code = neg ? CODE_MINUS : CODE_BLANK;

		up_b    = item_s1.buttons[0];
		down_b  = item_s1.buttons[1];
		onoff_b = item_s1.buttons[2];
		menu_b  = item_s1.buttons[3];

		sp_val  = 8'sd0;
		sp_mag  = 7'd0;
		sp_sign = CODE_BLANK;
		code    = digits_q[scan_q];

		out_d.segments      = 8'hFF;
		out_d.digit_select  = 4'd0;

		unique case (item_s1.req_type)
			REQ_SAMPLE: begin
				if (t != ERROR_TEMP && menu_q == MENU_VIEW) begin
					if (whole[11:7] == 5'd0 && w7 <= WHOLE_MAX) begin
						temp_d  = neg ? 8'(-{1'b0, r}) : 8'({1'b0, r});
						point_d = 1'b1;
						if (w7 >= 7'd10) begin
							digits_d[0] = sign_code;
							digits_d[1] = {1'b0, tens_of(w7)};
							digits_d[2] = {1'b0, ones_of(w7)};
						end else begin
							digits_d[0] = CODE_BLANK;
							digits_d[1] = sign_code;
							digits_d[2] = 5'(w7);
						end
						digits_d[3] = {1'b0, tenth};
					end
					// Hysteresis: release above the high setpoint, then engage below the low.
					if (thermo_q) begin
						if (relay_d && temp_d > high_q) begin
							relay_d = 1'b0;
						end
						if (!relay_d && temp_d < low_q) begin
							relay_d = 1'b1;
						end
					end else begin
						relay_d = 1'b0;
					end
				end
			end
			REQ_BUTTONS: begin
				if (thermo_q) begin
					unique case (menu_q)
						MENU_VIEW: begin
							if (menu_b) begin
								menu_d = MENU_EDIT_LOW;
							end
							if (onoff_b) begin
								thermo_d = 1'b0;
							end
						end
						MENU_EDIT_LOW: begin
							if (menu_b) begin
								menu_d = MENU_EDIT_HIGH;
							end
							if (down_b) begin
								low_d = step_set(low_d, 1'b0);
							end
							if (up_b) begin
								low_d = step_set(low_d, 1'b1);
							end
						end
						MENU_EDIT_HIGH: begin
							if (menu_b) begin
								menu_d = MENU_VIEW;
							end
							if (down_b) begin
								high_d = step_set(high_d, 1'b0);
							end
							if (up_b) begin
								high_d = step_set(high_d, 1'b1);
							end
						end
						default: begin
						end
					endcase
				end else if (onoff_b) begin
					thermo_d = 1'b1;
				end
				// While a setpoint is being edited the display shows it.
				if (menu_d == MENU_EDIT_LOW || menu_d == MENU_EDIT_HIGH) begin
					sp_val  = (menu_d == MENU_EDIT_LOW) ? low_d : high_d;
					sp_mag  = sp_val[7] ? 7'(-sp_val) : 7'(sp_val);
					sp_sign = sp_val[7] ? CODE_MINUS : CODE_BLANK;
					point_d = 1'b0;
					digits_d[0] = (menu_d == MENU_EDIT_LOW) ? CODE_LOWER : CODE_UPPER;
					if (sp_mag >= 7'd10) begin
						digits_d[1] = sp_sign;
						digits_d[2] = {1'b0, tens_of(sp_mag)};
						digits_d[3] = {1'b0, ones_of(sp_mag)};
					end else begin
						digits_d[1] = CODE_BLANK;
						digits_d[2] = sp_sign;
						digits_d[3] = 5'(sp_mag);
					end
				end
			end
			REQ_SCAN: begin
				out_d.segments = glyph(code);
				if (point_q && scan_q == POINT_DIGIT) begin
					out_d.segments[3] = 1'b0;
				end
				out_d.digit_select = pin_of(scan_q);
				scan_d = scan_q + 2'd1;
			end
			default: begin
			end
		endcase

		out_d.relay_on      = relay_d;
		out_d.thermostat_on = thermo_d;
		out_d.menu_state    = menu_d;
		out_d.shown_temp    = temp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thermo_q    <= 1'b0;
			menu_q      <= MENU_VIEW;
			low_q       <= LOW_DEFAULT;
			high_q      <= HIGH_DEFAULT;
			temp_q      <= 8'sd0;
			relay_q     <= 1'b0;
			digits_q[0] <= CODE_BLANK;
			digits_q[1] <= CODE_BLANK;
			digits_q[2] <= CODE_F;
			digits_q[3] <= CODE_ONE;
			point_q     <= 1'b0;
			scan_q      <= 2'd0;
		end else if (advance) begin
			thermo_q <= thermo_d;
			menu_q   <= menu_d;
			low_q    <= low_d;
			high_q   <= high_d;
			temp_q   <= temp_d;
			relay_q  <= relay_d;
			digits_q <= digits_d;
			point_q  <= point_d;
			scan_q   <= scan_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= out_d;
		end
	end

	`ASSERT_ALWAYS(a_low_in_range, (low_q >= SET_MIN && low_q <= SET_MAX), "low setpoint out of range")
	`ASSERT_ALWAYS(a_high_in_range, (high_q >= SET_MIN && high_q <= SET_MAX), "high setpoint out of range")
	`ASSERT_NEXT(a_result_follows, advance, out_valid_q, "processed item left no result")
	`ASSERT_NEXT(a_scan_steps, (advance && item_s1.req_type == REQ_SCAN), (scan_q == $past(scan_q) + 2'd1), "scan position did not advance")
	`ASSERT_IMPLIES(a_stall_needs_item, in_stall, (valid_s1 && out_valid_q), "input stalled with nothing held")

endmodule
